### design/lifo_cap_pkg.sv
package lifo_cap_pkg;

  // fixed field widths of the ports
  localparam int OPCODE_W   = 3;
  localparam int IDX_W      = 6;
  localparam int FIELD_W    = 7;
  localparam int OUT_WORD_W = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 7;

  // parameter defaults
  localparam int DEPTH_DEFAULT      = 64;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // reset values
  localparam int CAP_RESET     = 4;
  localparam int MIN_CAP_RESET = 4;

  // capacity policy: growth doubles, shrink halves at a quarter full
  localparam int GROW_SHIFT   = 1;
  localparam int HALVE_SHIFT  = 1;
  localparam int SHRINK_SHIFT = 2;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_PUSH    = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_POP     = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_PEEK    = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_READ_AT = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_SIZE    = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CAP = 4'd1;

  // moves of the cell chain, common to every cell
  typedef struct packed {
    logic push_shift;
    logic pop_shift;
    logic lane_load;
    logic lane_shift;
  } cell_ctrl_t;

endpackage

### design/lifo_stack_with_capacity_policy.sv
// LIFO stack of DATA_WIDTH-bit words held in a chain of DEPTH shift cells, with an
// occupancy count and a logical capacity that either stays fixed or grows by doubling
// (up to DEPTH) and shrinks by halving (down to the minimum capacity) at a quarter full.
// A request is taken when start is high and busy is low; its single result shows on
// the result ports for exactly one cycle with done_o high, and the receiver cannot
// stall it. For push, pop, peek, get size and clear, the result follows on the
// next cycle and a new request may come at once; the same holds for the unused
// opcodes and for a read at index past the top of the stack. A read at index that
// hits an entry makes the cells snapshot their words into a read lane that drains
// one cell per cycle toward the top, so the walk from the top cell down to the
// wanted entry sets how long the request lasts; busy is high during the walk.
// Configuration writes are always ready and should only be issued while idle.
module lifo_stack_with_capacity_policy #(
  parameter int DEPTH      = lifo_cap_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = lifo_cap_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                start,
  output logic                                busy,
  input  logic [lifo_cap_pkg::OPCODE_W-1:0]   opcode_i,
  input  logic [DATA_WIDTH-1:0]               push_word_i,
  input  logic [lifo_cap_pkg::IDX_W-1:0]      read_index_i,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lifo_cap_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lifo_cap_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // result strobe and fields
  output logic                                done_o,
  output logic                                ok_o,
  output logic [lifo_cap_pkg::OUT_WORD_W-1:0] read_word_o,
  output logic [lifo_cap_pkg::FIELD_W-1:0]    occupancy_o,
  output logic [lifo_cap_pkg::FIELD_W-1:0]    logical_capacity_o
);

  // cell 0 is the top of stack; cell k holds the entry k places below the top
  logic [DATA_WIDTH-1:0]    words [DEPTH];
  logic [DATA_WIDTH-1:0]    lanes [DEPTH];
  lifo_cap_pkg::cell_ctrl_t cell_ctrl;

  lifo_cap_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .busy_o             (busy),
    .opcode_i           (opcode_i),
    .read_index_i       (read_index_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .top_word_i         (words[0]),
    .lane_head_i        (lanes[0]),
    .cell_ctrl_o        (cell_ctrl),
    .done_o             (done_o),
    .ok_o               (ok_o),
    .read_word_o        (read_word_o),
    .occupancy_o        (occupancy_o),
    .logical_capacity_o (logical_capacity_o)
  );

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] above_word;
    logic [DATA_WIDTH-1:0] below_word;
    logic [DATA_WIDTH-1:0] below_lane;

    // a push enters at the top, a pop pulls the chain up; the bottom cell pulls zero
    if (k == 0) begin : g_top
      assign above_word = push_word_i;
    end else begin : g_mid
      assign above_word = words[k-1];
    end
    if (k == DEPTH - 1) begin : g_bottom
      assign below_word = '0;
      assign below_lane = '0;
    end else begin : g_inner
      assign below_word = words[k+1];
      assign below_lane = lanes[k+1];
    end

    lifo_cap_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .above_word_i (above_word),
      .below_word_i (below_word),
      .below_lane_i (below_lane),
      .word_o       (words[k]),
      .lane_o       (lanes[k])
    );
  end

endmodule

### design/lifo_cap_cell.sv
module lifo_cap_cell #(
  parameter int DATA_WIDTH = lifo_cap_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lifo_cap_pkg::cell_ctrl_t ctrl_i,
  input  logic [DATA_WIDTH-1:0]   above_word_i,
  input  logic [DATA_WIDTH-1:0]   below_word_i,
  input  logic [DATA_WIDTH-1:0]   below_lane_i,
  output logic [DATA_WIDTH-1:0]   word_o,
  output logic [DATA_WIDTH-1:0]   lane_o
);

  logic [DATA_WIDTH-1:0] word_q, word_d;
  logic [DATA_WIDTH-1:0] lane_q, lane_d;

  always_comb begin
    word_d = word_q;
    if (ctrl_i.push_shift) begin
      word_d = above_word_i;
    end else if (ctrl_i.pop_shift) begin
      word_d = below_word_i;
    end
  end

  // read lane: snapshot of the stack word, then drains toward the top cell
  always_comb begin
    lane_d = lane_q;
    if (ctrl_i.lane_load) begin
      lane_d = word_q;
    end else if (ctrl_i.lane_shift) begin
      lane_d = below_lane_i;
    end
  end

  // cell contents start out as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      lane_q <= '0;
    end else begin
      word_q <= word_d;
      lane_q <= lane_d;
    end
  end

  assign word_o = word_q;
  assign lane_o = lane_q;

endmodule

### design/lifo_cap_ctrl.sv
module lifo_cap_ctrl #(
  parameter int DEPTH      = lifo_cap_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = lifo_cap_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [lifo_cap_pkg::OPCODE_W-1:0]   opcode_i,
  input  logic [lifo_cap_pkg::IDX_W-1:0]      read_index_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lifo_cap_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lifo_cap_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [DATA_WIDTH-1:0]               top_word_i,
  input  logic [DATA_WIDTH-1:0]               lane_head_i,
  output lifo_cap_pkg::cell_ctrl_t            cell_ctrl_o,
  output logic                                done_o,
  output logic                                ok_o,
  output logic [lifo_cap_pkg::OUT_WORD_W-1:0] read_word_o,
  output logic [lifo_cap_pkg::FIELD_W-1:0]    occupancy_o,
  output logic [lifo_cap_pkg::FIELD_W-1:0]    logical_capacity_o
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int AW   = $clog2(DEPTH);
  localparam int BASE = (CW > lifo_cap_pkg::FIELD_W) ? CW : lifo_cap_pkg::FIELD_W;
  localparam int VW   = BASE + 1;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] cap_q, cap_d;
  logic          mode_q;
  logic [lifo_cap_pkg::CFG_DATA_W-1:0] min_cap_q;
  logic          busy_q, busy_d;
  logic [AW-1:0] rem_q, rem_d;
  logic          done_q, done_d;
  logic          ok_q, ok_d;
  logic [lifo_cap_pkg::OUT_WORD_W-1:0] word_q, word_d;

  logic [VW-1:0] count_ext, cap_ext, idx_ext, depth_ext, floor_cap, min_ext;
  logic [VW-1:0] dbl_cap, grown_cap, half_cap, shrunk_cap, target_full, cnt_m1_ext;
  logic [CW-1:0] cnt_m1;
  logic          full, grow_fail;

  always_comb begin
    count_ext = VW'(count_q);
    cap_ext   = VW'(cap_q);
    idx_ext   = VW'(read_index_i);
    depth_ext = VW'(DEPTH);
    min_ext   = VW'(min_cap_q);
    // out-of-range minimum clamps to 1 .. DEPTH
    if (min_ext == '0) begin
      floor_cap = VW'(1);
    end else if (min_ext > depth_ext) begin
      floor_cap = depth_ext;
    end else begin
      floor_cap = min_ext;
    end
    full       = count_ext >= cap_ext;
    grow_fail  = mode_q || (cap_ext >= depth_ext);
    dbl_cap    = cap_ext << lifo_cap_pkg::GROW_SHIFT;
    grown_cap  = (dbl_cap > depth_ext) ? depth_ext : dbl_cap;
    cnt_m1     = count_q - CW'(1);
    cnt_m1_ext = VW'(cnt_m1);
    half_cap   = cap_ext >> lifo_cap_pkg::HALVE_SHIFT;
    shrunk_cap = (half_cap < floor_cap) ? floor_cap : half_cap;
    // read position from the bottom maps to a cell distance from the top
    target_full = count_ext - VW'(1) - idx_ext;
  end

  always_comb begin
    count_d     = count_q;
    cap_d       = cap_q;
    busy_d      = busy_q;
    rem_d       = rem_q;
    done_d      = 1'b0;
    ok_d        = 1'b0;
    word_d      = '0;
    cell_ctrl_o = '0;
    if (busy_q) begin
      if (rem_q == '0) begin
        done_d = 1'b1;
        ok_d   = 1'b1;
        word_d = lifo_cap_pkg::OUT_WORD_W'(lane_head_i);
        busy_d = 1'b0;
      end else begin
        cell_ctrl_o.lane_shift = 1'b1;
        rem_d = rem_q - AW'(1);
      end
    end else if (start_i) begin
      done_d = 1'b1;
      case (opcode_i)
        lifo_cap_pkg::OP_PUSH: begin
          if (full && !grow_fail) begin
            cap_d = CW'(grown_cap);
          end
          if ((!full || !grow_fail) && (count_ext < depth_ext)) begin
            cell_ctrl_o.push_shift = 1'b1;
            count_d = count_q + CW'(1);
            ok_d    = 1'b1;
          end
        end
        lifo_cap_pkg::OP_POP: begin
          if (count_q != '0) begin
            cell_ctrl_o.pop_shift = 1'b1;
            count_d = cnt_m1;
            ok_d    = 1'b1;
            word_d  = lifo_cap_pkg::OUT_WORD_W'(top_word_i);
            if (!mode_q && (cap_ext > floor_cap) &&
                (cnt_m1_ext <= (cap_ext >> lifo_cap_pkg::SHRINK_SHIFT))) begin
              cap_d = CW'(shrunk_cap);
            end
          end
        end
        lifo_cap_pkg::OP_PEEK: begin
          if (count_q != '0) begin
            ok_d   = 1'b1;
            word_d = lifo_cap_pkg::OUT_WORD_W'(top_word_i);
          end
        end
        lifo_cap_pkg::OP_READ_AT: begin
          if (idx_ext < count_ext) begin
            // result comes later from the drained read lane
            done_d = 1'b0;
            cell_ctrl_o.lane_load = 1'b1;
            busy_d = 1'b1;
            rem_d  = target_full[AW-1:0];
          end
        end
        lifo_cap_pkg::OP_SIZE: begin
          ok_d = 1'b1;
        end
        lifo_cap_pkg::OP_CLEAR: begin
          count_d = '0;
          cap_d   = CW'(floor_cap);
          ok_d    = 1'b1;
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      cap_q     <= CW'(lifo_cap_pkg::CAP_RESET);
      mode_q    <= 1'b0;
      min_cap_q <= lifo_cap_pkg::CFG_DATA_W'(lifo_cap_pkg::MIN_CAP_RESET);
      busy_q    <= 1'b0;
      rem_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      cap_q   <= cap_d;
      busy_q  <= busy_d;
      rem_q   <= rem_d;
      done_q  <= done_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == lifo_cap_pkg::CFG_MODE) begin
          mode_q <= cfg_data_i[0];
        end else if (cfg_index_i == lifo_cap_pkg::CFG_MIN_CAP) begin
          min_cap_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q   <= ok_d;
    word_q <= word_d;
  end

  assign busy_o      = busy_q;
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign ok_o        = ok_q;
  assign read_word_o = word_q;
  // count and capacity registers already hold the post-request values while done is high
  assign occupancy_o        = lifo_cap_pkg::FIELD_W'(count_q);
  assign logical_capacity_o = lifo_cap_pkg::FIELD_W'(cap_q);

endmodule

### test/lifo_stack_with_capacity_policy_tb.sv
`timescale 1ns / 1ps

module lifo_stack_with_capacity_policy_tb;

  localparam int DEPTH = lifo_cap_pkg::DEPTH_DEFAULT;
  // cycles with no handshake and no result before the run is called hung
  localparam int STALL_LIMIT = 2000;

  // opcodes the block ignores
  localparam logic [lifo_cap_pkg::OPCODE_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [lifo_cap_pkg::OPCODE_W-1:0] OP_SPARE_B = 3'd7;
  // register index with nothing behind it
  localparam logic [lifo_cap_pkg::CFG_IDX_W-1:0] CFG_SPARE = 4'd9;

  typedef struct {
    logic                                ok;
    logic [lifo_cap_pkg::OUT_WORD_W-1:0] word;
    logic [lifo_cap_pkg::FIELD_W-1:0]    occ;
    logic [lifo_cap_pkg::FIELD_W-1:0]    cap;
  } stack_result_t;

  logic                                clk_i        = 1'b0;
  logic                                rst_ni       = 1'b0;
  logic                                start        = 1'b0;
  logic                                busy;
  logic [lifo_cap_pkg::OPCODE_W-1:0]   opcode_i     = '0;
  logic [31:0]                         push_word_i  = '0;
  logic [lifo_cap_pkg::IDX_W-1:0]      read_index_i = '0;
  logic                                cfg_valid_i  = 1'b0;
  logic                                cfg_ready_o;
  logic [lifo_cap_pkg::CFG_IDX_W-1:0]  cfg_index_i  = '0;
  logic [lifo_cap_pkg::CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                                done_o;
  logic                                ok_o;
  logic [lifo_cap_pkg::OUT_WORD_W-1:0] read_word_o;
  logic [lifo_cap_pkg::FIELD_W-1:0]    occupancy_o;
  logic [lifo_cap_pkg::FIELD_W-1:0]    logical_capacity_o;

  lifo_stack_with_capacity_policy i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .opcode_i           (opcode_i),
    .push_word_i        (push_word_i),
    .read_index_i       (read_index_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .done_o             (done_o),
    .ok_o               (ok_o),
    .read_word_o        (read_word_o),
    .occupancy_o        (occupancy_o),
    .logical_capacity_o (logical_capacity_o)
  );

  initial forever #2 clk_i = ~clk_i;

  // shadow copy of the stack and its registers
  logic [31:0]                      stk_mem [DEPTH];
  int                               stk_count = 0;
  int                               stk_cap   = lifo_cap_pkg::CAP_RESET;
  logic                             cfg_mode  = 1'b0;
  logic [lifo_cap_pkg::FIELD_W-1:0] cfg_min   = lifo_cap_pkg::MIN_CAP_RESET;

  stack_result_t expected_q [$];

  int gap_pct      = 0;   // chance in percent that the sender idles a cycle
  int n_requests   = 0;
  int n_results    = 0;
  int n_cfg_writes = 0;
  int n_errors     = 0;
  int stall_cycles = 0;

  // minimum capacity as the block applies it: 0 acts as 1, above depth as depth
  function automatic int capacity_floor();
    int m;
    m = cfg_min;
    if (m == 0) m = 1;
    if (m > DEPTH) m = DEPTH;
    return m;
  endfunction

  // applies one request to the shadow stack and returns its result
  function automatic stack_result_t predict_stack(
      input logic [lifo_cap_pkg::OPCODE_W-1:0] op,
      input logic [31:0]                       word,
      input logic [lifo_cap_pkg::IDX_W-1:0]    idx);
    stack_result_t r;
    logic          can_push;
    int            fl;
    int            nc;
    r.ok   = 1'b0;
    r.word = '0;
    case (op)
      lifo_cap_pkg::OP_PUSH: begin
        can_push = 1'b1;
        if (stk_count >= stk_cap) begin
          // full: fixed mode refuses, dynamic mode doubles up to the depth
          if (cfg_mode || stk_cap >= DEPTH) can_push = 1'b0;
          else stk_cap = (stk_cap * 2 > DEPTH) ? DEPTH : stk_cap * 2;
        end
        if (can_push && stk_count < DEPTH) begin
          stk_mem[stk_count] = word;
          stk_count++;
          r.ok = 1'b1;
        end
      end
      lifo_cap_pkg::OP_POP: begin
        if (stk_count > 0) begin
          stk_count--;
          r.word = stk_mem[stk_count];
          r.ok   = 1'b1;
          // dynamic mode halves at a quarter full, never below the floor
          if (!cfg_mode) begin
            fl = capacity_floor();
            if (stk_cap > fl && stk_count <= stk_cap / 4) begin
              nc = stk_cap / 2;
              stk_cap = (nc < fl) ? fl : nc;
            end
          end
        end
      end
      lifo_cap_pkg::OP_PEEK: begin
        if (stk_count > 0) begin
          r.word = stk_mem[stk_count - 1];
          r.ok   = 1'b1;
        end
      end
      lifo_cap_pkg::OP_READ_AT: begin
        if (idx < stk_count) begin
          r.word = stk_mem[idx];
          r.ok   = 1'b1;
        end
      end
      lifo_cap_pkg::OP_SIZE: r.ok = 1'b1;
      lifo_cap_pkg::OP_CLEAR: begin
        stk_count = 0;
        stk_cap   = capacity_floor();
        r.ok      = 1'b1;
      end
      default: ;  // spare opcodes leave everything as it was
    endcase
    r.occ = stk_count[lifo_cap_pkg::FIELD_W-1:0];
    r.cap = stk_cap[lifo_cap_pkg::FIELD_W-1:0];
    return r;
  endfunction

  // one request: optional random gap, then hold start until busy is low at an edge.
  // start is left high so a following request can go back to back
  task automatic send_req(input logic [lifo_cap_pkg::OPCODE_W-1:0] op,
                          input logic [31:0] word,
                          input logic [lifo_cap_pkg::IDX_W-1:0] idx);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    opcode_i     <= op;
    push_word_i  <= word;
    read_index_i <= idx;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_q.push_back(predict_stack(op, word, idx));
    n_requests++;
  endtask

  // drop start and let every outstanding result come back
  task automatic wait_drained();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // register write; valid stays high so writes can chain, caller lowers it
  task automatic write_reg(input logic [lifo_cap_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lifo_cap_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    n_cfg_writes++;
    case (idx)
      lifo_cap_pkg::CFG_MODE:    cfg_mode = data[0];
      lifo_cap_pkg::CFG_MIN_CAP: cfg_min  = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [lifo_cap_pkg::CFG_DATA_W-1:0] mode_data,
                           input logic [lifo_cap_pkg::CFG_DATA_W-1:0] min_data);
    wait_drained();
    write_reg(lifo_cap_pkg::CFG_MODE, mode_data);
    write_reg(lifo_cap_pkg::CFG_MIN_CAP, min_data);
    cfg_valid_i <= 1'b0;
  endtask

  // result checker: each strobe against the oldest expectation
  always @(posedge clk_i) begin : check_results
    stack_result_t want;
    if (rst_ni && done_o) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding");
        n_errors++;
      end else begin
        want = expected_q.pop_front();
        if (ok_o !== want.ok) begin
          $error("ok: expected %0d, actual %0d", want.ok, ok_o);
          n_errors++;
        end
        if (read_word_o !== want.word) begin
          $error("read_word: expected %h, actual %h", want.word, read_word_o);
          n_errors++;
        end
        if (occupancy_o !== want.occ) begin
          $error("occupancy: expected %0d, actual %0d", want.occ, occupancy_o);
          n_errors++;
        end
        if (logical_capacity_o !== want.cap) begin
          $error("logical_capacity: expected %0d, actual %0d", want.cap, logical_capacity_o);
          n_errors++;
        end
      end
    end
  end

  // watchdog: any handshake or result restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d idle cycles", stall_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // everything but get size fails on the empty stack right after reset
  task automatic test_empty_stack();
    send_req(lifo_cap_pkg::OP_SIZE, 32'h0, 6'd0);
    send_req(lifo_cap_pkg::OP_POP, 32'h0, 6'd0);
    send_req(lifo_cap_pkg::OP_PEEK, 32'h0, 6'd0);
    send_req(lifo_cap_pkg::OP_READ_AT, 32'h0, 6'd0);
    send_req(lifo_cap_pkg::OP_READ_AT, 32'h0, 6'd63);
    send_req(OP_SPARE_A, $urandom, 6'($urandom));
    send_req(OP_SPARE_B, $urandom, 6'($urandom));
  endtask

  // default dynamic policy: grow 4 -> 8 on the fifth push, halve back on the pops
  task automatic test_growth_and_shrink();
    send_req(lifo_cap_pkg::OP_PUSH, 32'hFFFF_FFFF, 6'd0);
    send_req(lifo_cap_pkg::OP_PUSH, 32'h0000_0000, 6'd0);
    send_req(lifo_cap_pkg::OP_PUSH, 32'hA5A5_A5A5, 6'd0);
    send_req(lifo_cap_pkg::OP_PUSH, 32'h5A5A_5A5A, 6'd0);
    send_req(lifo_cap_pkg::OP_PUSH, 32'h1234_5678, 6'd0);
    send_req(lifo_cap_pkg::OP_PEEK, 32'h0, 6'd0);
    send_req(lifo_cap_pkg::OP_READ_AT, 32'h0, 6'd0);
    send_req(lifo_cap_pkg::OP_READ_AT, 32'h0, 6'd4);
    send_req(lifo_cap_pkg::OP_READ_AT, 32'h0, 6'd5);  // one past the top
    send_req(lifo_cap_pkg::OP_SIZE, 32'h0, 6'd0);
    repeat (6) send_req(lifo_cap_pkg::OP_POP, 32'h0, 6'd0);  // last one on the empty stack
    send_req(lifo_cap_pkg::OP_CLEAR, 32'h0, 6'd0);
  endtask

  // fixed mode at both ends of the minimum, then a mode change on a full stack
  task automatic test_fixed_capacity();
    configure(7'h7F, 7'd1);  // upper data bits set, only bit 0 picks the mode
    send_req(lifo_cap_pkg::OP_CLEAR, 32'h0, 6'd0);
    send_req(lifo_cap_pkg::OP_PUSH, $urandom, 6'd0);
    send_req(lifo_cap_pkg::OP_PUSH, $urandom, 6'd0);  // full at capacity one
    send_req(lifo_cap_pkg::OP_PEEK, 32'h0, 6'd0);
    send_req(lifo_cap_pkg::OP_POP, 32'h0, 6'd0);
    send_req(lifo_cap_pkg::OP_POP, 32'h0, 6'd0);
    configure(7'h01, 7'd127);  // minimum above depth acts as depth
    send_req(lifo_cap_pkg::OP_CLEAR, 32'h0, 6'd0);
    repeat (DEPTH + 1) send_req(lifo_cap_pkg::OP_PUSH, $urandom, 6'd0);
    send_req(lifo_cap_pkg::OP_READ_AT, 32'h0, 6'd63);
    send_req(lifo_cap_pkg::OP_READ_AT, 32'h0, 6'd0);
    // back to dynamic with a register index in between that maps to nothing
    wait_drained();
    write_reg(lifo_cap_pkg::CFG_MODE, 7'h7E);
    write_reg(CFG_SPARE, 7'h7F);
    write_reg(lifo_cap_pkg::CFG_MIN_CAP, 7'd127);
    cfg_valid_i <= 1'b0;
    send_req(lifo_cap_pkg::OP_PUSH, $urandom, 6'd0);  // capacity already at depth
    repeat (DEPTH) send_req(lifo_cap_pkg::OP_POP, 32'h0, 6'd0);
  endtask

  // minimum of zero acts as one: full doubling chain up to depth and back down
  task automatic test_min_capacity_floor();
    configure(7'h00, 7'd0);
    send_req(lifo_cap_pkg::OP_CLEAR, 32'h0, 6'd0);
    repeat (DEPTH + 2) send_req(lifo_cap_pkg::OP_PUSH, $urandom, 6'd0);
    repeat (4) send_req(lifo_cap_pkg::OP_READ_AT, 32'h0, 6'($urandom_range(DEPTH - 1)));
    repeat (DEPTH) send_req(lifo_cap_pkg::OP_POP, 32'h0, 6'd0);
    configure(7'h00, 7'd64);
    send_req(lifo_cap_pkg::OP_CLEAR, 32'h0, 6'd0);
    send_req(lifo_cap_pkg::OP_SIZE, 32'h0, 6'd0);
  endtask

  function automatic logic [lifo_cap_pkg::OPCODE_W-1:0] pick_any_op();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) return lifo_cap_pkg::OP_PUSH;
    if (roll < 54) return lifo_cap_pkg::OP_POP;
    if (roll < 64) return lifo_cap_pkg::OP_PEEK;
    if (roll < 78) return lifo_cap_pkg::OP_READ_AT;
    if (roll < 88) return lifo_cap_pkg::OP_SIZE;
    if (roll < 94) return lifo_cap_pkg::OP_CLEAR;
    if (roll < 97) return OP_SPARE_A;
    return OP_SPARE_B;
  endfunction

  // bursts of mostly pushes, mostly pops or a mix, so the stack swings full and empty
  task automatic run_traffic(input int n);
    int                                burst_left;
    int                                kind;
    int                                roll;
    logic [lifo_cap_pkg::OPCODE_W-1:0] op;
    logic [31:0]                       word;
    logic [lifo_cap_pkg::IDX_W-1:0]    idx;
    burst_left = 0;
    kind       = 0;
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        kind       = $urandom_range(3);
        burst_left = $urandom_range(40, 1);
      end
      burst_left--;
      roll = $urandom_range(99);
      case (kind)
        0:       op = (roll < 85) ? lifo_cap_pkg::OP_PUSH : pick_any_op();
        1:       op = (roll < 85) ? lifo_cap_pkg::OP_POP : pick_any_op();
        default: op = pick_any_op();
      endcase
      case ($urandom_range(9))
        0:       word = 32'h0;
        1:       word = 32'hFFFF_FFFF;
        default: word = $urandom;
      endcase
      // index mostly inside the stack, sometimes anywhere
      if (stk_count > 0 && $urandom_range(4) != 0) begin
        idx = lifo_cap_pkg::IDX_W'($urandom_range(stk_count - 1));
      end else begin
        idx = lifo_cap_pkg::IDX_W'($urandom_range(63));
      end
      send_req(op, word, idx);
    end
  endtask

  // phases step through both modes, the minimum extremes and three gap rates
  task automatic test_random_traffic();
    logic [lifo_cap_pkg::CFG_DATA_W-1:0] min_pick;
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0:       min_pick = 7'd4;
        1:       min_pick = 7'd1;
        2:       min_pick = 7'd64;
        3:       min_pick = 7'd0;
        4:       min_pick = 7'd127;
        5:       min_pick = 7'd65;
        default: min_pick = lifo_cap_pkg::CFG_DATA_W'($urandom_range(127));
      endcase
      configure({6'($urandom), ph[0]}, min_pick);
      case (ph % 3)
        0:       gap_pct = 0;
        1:       gap_pct = 60;
        default: gap_pct = 33;
      endcase
      run_traffic(180);
      gap_pct = 0;
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) stk_mem[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_stack();
    test_growth_and_shrink();
    test_fixed_capacity();
    test_min_capacity_floor();
    test_random_traffic();

    // drain, then a tail for any stray result
    wait_drained();
    repeat (DEPTH + 8) @(posedge clk_i);

    $display("covered %0d requests, %0d results checked, %0d register writes",
             n_requests, n_results, n_cfg_writes);
    $display("both capacity modes, minimum from 0 to 127, growth to depth, sender gaps");
    if (n_errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
